// File: hw/rtl/bbpf_pkg.sv
// ----------------------------------------------------------------------------
// bbpf_pkg
// Shared types and constants for the byte budget packet descriptor fifo.
// ----------------------------------------------------------------------------
package bbpf_pkg;

    // queue geometry
    localparam int DEPTH  = 1024;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // descriptor field widths
    localparam int HANDLE_W = 32;
    localparam int SIZE_W   = 24;
    localparam int BYTES_W  = 32;
    localparam int ACT_W    = 2;
    localparam int STAT_W   = 2;

    localparam logic [BYTES_W-1:0] BYTE_LIMIT_RESET = 32'd1048576;

    // request opcodes
    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH  = 2'd0,
        ACT_POP   = 2'd1,
        ACT_FLUSH = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // one stored descriptor
    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [SIZE_W-1:0]   size;
    } desc_t;

    // controller to datapath commands
    typedef struct packed {
        logic accept;   // latch request, start memory read
        logic exec;     // update queue state, load result register
    } cmd_t;

endpackage

// File: hw/rtl/bbpf_ctrl.sv
// ----------------------------------------------------------------------------
// bbpf_ctrl
// Sequencer for the descriptor fifo: accepts a request, runs the execute
// cycle and owns the result valid flag.
// ----------------------------------------------------------------------------
module bbpf_ctrl
    import bbpf_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    output logic m_valid,
    input  logic m_ready,
    output cmd_t cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   out_free;

    // result register is free now or drains at this edge
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;

    // execute holds until the result register can take the new result
    assign cmd.accept = s_valid && s_ready;
    assign cmd.exec   = (state_reg == S_EXEC) && out_free;

    // next state and result valid
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (cmd.accept) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    state_next   = S_IDLE;
                    m_valid_next = 1'b1;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// File: hw/rtl/bbpf_dpath.sv
// ----------------------------------------------------------------------------
// bbpf_dpath
// Descriptor memory, ring pointers, entry count, byte total, byte limit
// register and the result register.
// ----------------------------------------------------------------------------
module bbpf_dpath
    import bbpf_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  cmd_t                cmd,
    input  logic [ACT_W-1:0]    s_action,
    input  logic [HANDLE_W-1:0] s_pkt_handle,
    input  logic [SIZE_W-1:0]   s_pkt_size,
    input  logic                cfg_valid,
    input  logic [BYTES_W-1:0]  cfg_byte_limit,
    output logic [STAT_W-1:0]   m_status,
    output logic [HANDLE_W-1:0] m_out_handle,
    output logic [SIZE_W-1:0]   m_out_size,
    output logic [CNT_W-1:0]    m_entry_total,
    output logic [BYTES_W-1:0]  m_bytes_held
);

    // descriptor storage, no reset
    desc_t mem [DEPTH];
    desc_t rd_data_reg;

    // latched request
    action_t             act_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic [SIZE_W-1:0]   size_reg;

    // queue state
    logic [PTR_W-1:0]   rd_ptr_reg,   rd_ptr_next;
    logic [PTR_W-1:0]   wr_ptr_reg,   wr_ptr_next;
    logic [CNT_W-1:0]   count_reg,    count_next;
    logic [BYTES_W-1:0] bytes_reg,    bytes_next;
    logic [BYTES_W-1:0] limit_reg;

    // result register
    status_t             stat_reg,  stat_next;
    logic [HANDLE_W-1:0] ohandle_reg, ohandle_next;
    logic [SIZE_W-1:0]   osize_reg,   osize_next;
    logic [CNT_W-1:0]    ototal_reg;
    logic [BYTES_W-1:0]  obytes_reg;

    logic [BYTES_W:0]   push_sum;
    logic               over_budget;
    logic               is_full;
    logic               is_empty;
    logic               push_ok;
    logic               pop_ok;

    // budget and occupancy checks
    assign push_sum    = {1'b0, bytes_reg} + {{(BYTES_W + 1 - SIZE_W){1'b0}}, size_reg};
    assign over_budget = push_sum > {1'b0, limit_reg};
    assign is_full     = (count_reg == CNT_W'(DEPTH));
    assign is_empty    = (count_reg == '0);
    assign push_ok     = cmd.exec && (act_reg == ACT_PUSH) && !over_budget && !is_full;
    assign pop_ok      = cmd.exec && (act_reg == ACT_POP) && !is_empty;

    // queue state update and result
    always_comb begin
        rd_ptr_next  = rd_ptr_reg;
        wr_ptr_next  = wr_ptr_reg;
        count_next   = count_reg;
        bytes_next   = bytes_reg;
        stat_next    = ST_OK;
        ohandle_next = '0;
        osize_next   = '0;
        case (act_reg)
            ACT_PUSH: begin
                if (push_ok) begin
                    wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                  : wr_ptr_reg + PTR_W'(1);
                    count_next  = count_reg + CNT_W'(1);
                    bytes_next  = push_sum[BYTES_W-1:0];
                end else begin
                    stat_next = ST_FULL;
                end
            end
            ACT_POP: begin
                if (pop_ok) begin
                    rd_ptr_next  = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                   : rd_ptr_reg + PTR_W'(1);
                    count_next   = count_reg - CNT_W'(1);
                    ohandle_next = rd_data_reg.handle;
                    osize_next   = rd_data_reg.size;
                    bytes_next   = (bytes_reg >= BYTES_W'(rd_data_reg.size))
                                   ? bytes_reg - BYTES_W'(rd_data_reg.size) : '0;
                end else begin
                    stat_next = ST_EMPTY;
                end
            end
            ACT_FLUSH: begin
                rd_ptr_next = '0;
                wr_ptr_next = '0;
                count_next  = '0;
                bytes_next  = '0;
            end
            default: begin
            end
        endcase
    end

    // memory write and registered read
    always_ff @(posedge aclk) begin
        if (push_ok) begin
            mem[wr_ptr_reg] <= '{handle: handle_reg, size: size_reg};
        end
        if (cmd.accept) begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    // request latch and result payload
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            act_reg    <= action_t'(s_action);
            handle_reg <= s_pkt_handle;
            size_reg   <= s_pkt_size;
        end
        if (cmd.exec) begin
            stat_reg    <= stat_next;
            ohandle_reg <= ohandle_next;
            osize_reg   <= osize_next;
            ototal_reg  <= count_next;
            obytes_reg  <= bytes_next;
        end
    end

    // control state: pointers, count, byte total, limit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
            bytes_reg  <= '0;
            limit_reg  <= BYTE_LIMIT_RESET;
        end else begin
            if (cmd.exec) begin
                rd_ptr_reg <= rd_ptr_next;
                wr_ptr_reg <= wr_ptr_next;
                count_reg  <= count_next;
                bytes_reg  <= bytes_next;
            end
            if (cfg_valid) begin
                limit_reg <= cfg_byte_limit;
            end
        end
    end

    assign m_status      = stat_reg;
    assign m_out_handle  = ohandle_reg;
    assign m_out_size    = osize_reg;
    assign m_entry_total = ototal_reg;
    assign m_bytes_held  = obytes_reg;

endmodule

// File: hw/rtl/byte_budget_packet_fifo.sv
// After a request is accepted, the execute state loads the result register and
// m_valid rises once the output register is free.
// No new request is accepted while one is in execute (registered memory read, then execute).
// A waiting result does not block the next accept; that request holds in execute
// until the output register drains.
// Reset (aresetn low, synchronous) empties the queue and loads byte_limit = 1048576.
// ----------------------------------------------------------------------------
// byte_budget_packet_fifo
// Ring fifo of packet descriptors with a byte budget on the total held size.
// ----------------------------------------------------------------------------
module byte_budget_packet_fifo
    import bbpf_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [ACT_W-1:0]    s_action,
    input  logic [HANDLE_W-1:0] s_pkt_handle,
    input  logic [SIZE_W-1:0]   s_pkt_size,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STAT_W-1:0]   m_status,
    output logic [HANDLE_W-1:0] m_out_handle,
    output logic [SIZE_W-1:0]   m_out_size,
    output logic [CNT_W-1:0]    m_entry_total,
    output logic [BYTES_W-1:0]  m_bytes_held,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [BYTES_W-1:0]  cfg_byte_limit
);

    cmd_t cmd;

    // limit register takes a write every cycle
    assign cfg_ready = 1'b1;

    // sequencer
    bbpf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // queue storage and arithmetic
    bbpf_dpath u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .s_action       (s_action),
        .s_pkt_handle   (s_pkt_handle),
        .s_pkt_size     (s_pkt_size),
        .cfg_valid      (cfg_valid),
        .cfg_byte_limit (cfg_byte_limit),
        .m_status       (m_status),
        .m_out_handle   (m_out_handle),
        .m_out_size     (m_out_size),
        .m_entry_total  (m_entry_total),
        .m_bytes_held   (m_bytes_held)
    );

endmodule

// File: hw/rtl/bbpf_checker.sv
// ----------------------------------------------------------------------------
// bbpf_checker
// Port level checks for byte_budget_packet_fifo, attached by bind.
// ----------------------------------------------------------------------------
module bbpf_checker
    import bbpf_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input logic [STAT_W-1:0]   m_status,
    input logic [HANDLE_W-1:0] m_out_handle,
    input logic [SIZE_W-1:0]   m_out_size,
    input logic [CNT_W-1:0]    m_entry_total
);

    // one request in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while previous one still executing");

    // every accepted request shows a result
    a_result_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |-> ##2 m_valid)
        else $error("result missing after accepted request");

    // stalled result keeps its status
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status))
        else $error("stalled result dropped or changed");

    // descriptor fields are zero unless the status is ok
    a_zero_on_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ST_OK) |-> (m_out_handle == '0) && (m_out_size == '0))
        else $error("nonzero descriptor on failed request");

    // entry count never exceeds the queue depth
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_entry_total <= CNT_W'(DEPTH))
        else $error("entry count beyond queue depth");

endmodule

bind byte_budget_packet_fifo bbpf_checker u_bbpf_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_status      (m_status),
    .m_out_handle  (m_out_handle),
    .m_out_size    (m_out_size),
    .m_entry_total (m_entry_total)
);

// File: tb/tb_byte_budget_packet_fifo.sv
// ----------------------------------------------------------------------------
// tb_byte_budget_packet_fifo
// Self-checking bench for the byte budget packet descriptor fifo. Requests are
// mirrored into a shadow queue that predicts every result, and each result
// leaving the block is compared field by field against the oldest prediction.
// Covers the byte budget edges, the 32-bit byte ceiling, flush, limit changes
// while loaded, output backpressure and randomized mixed traffic.
// ----------------------------------------------------------------------------
module tb_byte_budget_packet_fifo;

    timeunit 1ns;
    timeprecision 1ps;

    import bbpf_pkg::*;

    localparam int TIMEOUT_NS        = 2_000_000;
    localparam int SINK_HOLD_CYCLES  = 300;
    localparam int MAX_REPORTS       = 10;

    // one predicted result
    typedef struct {
        status_t             status;
        logic [HANDLE_W-1:0] handle;
        logic [SIZE_W-1:0]   size;
        logic [CNT_W-1:0]    count;
        logic [BYTES_W-1:0]  bytes;
    } fifo_result_t;

    logic                aclk           = 1'b0;
    logic                aresetn        = 1'b0;
    logic                s_valid        = 1'b0;
    logic                s_ready;
    logic [ACT_W-1:0]    s_action       = '0;
    logic [HANDLE_W-1:0] s_pkt_handle   = '0;
    logic [SIZE_W-1:0]   s_pkt_size     = '0;
    logic                m_valid;
    logic                m_ready        = 1'b0;
    logic [STAT_W-1:0]   m_status;
    logic [HANDLE_W-1:0] m_out_handle;
    logic [SIZE_W-1:0]   m_out_size;
    logic [CNT_W-1:0]    m_entry_total;
    logic [BYTES_W-1:0]  m_bytes_held;
    logic                cfg_valid      = 1'b0;
    logic                cfg_ready;
    logic [BYTES_W-1:0]  cfg_byte_limit = BYTE_LIMIT_RESET;

    // shadow copy of the queue
    logic [HANDLE_W-1:0] shadow_handle [DEPTH];
    logic [SIZE_W-1:0]   shadow_size   [DEPTH];
    int                  shadow_rd     = 0;
    int                  shadow_wr     = 0;
    int                  shadow_count  = 0;
    logic [BYTES_W-1:0]  shadow_bytes  = '0;
    logic [BYTES_W-1:0]  shadow_limit  = BYTE_LIMIT_RESET;

    fifo_result_t        pending_results[$];

    int  requests_sent  = 0;
    int  results_seen   = 0;
    int  mismatch_count = 0;
    int  burst_left     = 0;
    bit  sink_hold_req  = 1'b0;
    int  n_push_ok      = 0;
    int  n_push_full    = 0;
    int  n_pop_ok       = 0;
    int  n_pop_empty    = 0;
    int  n_flush        = 0;
    int  n_idle_action  = 0;
    int  peak_count     = 0;

    byte_budget_packet_fifo u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_pkt_handle   (s_pkt_handle),
        .s_pkt_size     (s_pkt_size),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_out_handle   (m_out_handle),
        .m_out_size     (m_out_size),
        .m_entry_total  (m_entry_total),
        .m_bytes_held   (m_bytes_held),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_byte_limit (cfg_byte_limit)
    );

    // clock
    initial begin
        forever #2 aclk = ~aclk;
    end

    // watchdog
    initial begin
        #TIMEOUT_NS;
        $display("simulation failed");
        $finish;
    end

    // apply one request to the shadow queue and return its result
    function automatic fifo_result_t predict_result(action_t act,
                                                    logic [HANDLE_W-1:0] handle,
                                                    logic [SIZE_W-1:0] size);
        fifo_result_t       r;
        logic [BYTES_W:0]   sum;
        r.status = ST_OK;
        r.handle = '0;
        r.size   = '0;
        // 33-bit sum so the budget test cannot wrap
        sum = {1'b0, shadow_bytes} + {{(BYTES_W + 1 - SIZE_W){1'b0}}, size};
        case (act)
            ACT_PUSH: begin
                if (sum > {1'b0, shadow_limit} || shadow_count >= DEPTH) begin
                    r.status = ST_FULL;
                    n_push_full++;
                end else begin
                    shadow_handle[PTR_W'(shadow_wr)] = handle;
                    shadow_size[PTR_W'(shadow_wr)]   = size;
                    shadow_wr    = (shadow_wr == DEPTH - 1) ? 0 : shadow_wr + 1;
                    shadow_count++;
                    shadow_bytes = sum[BYTES_W-1:0];
                    n_push_ok++;
                    if (shadow_count > peak_count)
                        peak_count = shadow_count;
                end
            end
            ACT_POP: begin
                if (shadow_count == 0) begin
                    r.status = ST_EMPTY;
                    n_pop_empty++;
                end else begin
                    r.handle     = shadow_handle[PTR_W'(shadow_rd)];
                    r.size       = shadow_size[PTR_W'(shadow_rd)];
                    shadow_rd    = (shadow_rd == DEPTH - 1) ? 0 : shadow_rd + 1;
                    shadow_count--;
                    shadow_bytes = (shadow_bytes >= BYTES_W'(r.size))
                                   ? shadow_bytes - BYTES_W'(r.size) : '0;
                    n_pop_ok++;
                end
            end
            ACT_FLUSH: begin
                shadow_rd    = 0;
                shadow_wr    = 0;
                shadow_count = 0;
                shadow_bytes = '0;
                n_flush++;
            end
            default: begin
                n_idle_action++;
            end
        endcase
        r.count = CNT_W'(shadow_count);
        r.bytes = shadow_bytes;
        return r;
    endfunction

    function automatic void flag_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    // result checking, then prediction of newly accepted requests
    always @(posedge aclk) begin : check_and_predict
        fifo_result_t oldest;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                flag_mismatch($sformatf("result with nothing outstanding st=%0d h=%h sz=%h",
                                        m_status, m_out_handle, m_out_size));
            end else begin
                oldest = pending_results.pop_front();
                if (m_status !== oldest.status || m_out_handle !== oldest.handle ||
                    m_out_size !== oldest.size || m_entry_total !== oldest.count ||
                    m_bytes_held !== oldest.bytes) begin
                    flag_mismatch($sformatf(
                        {"expected st=%0d h=%h sz=%h cnt=%0d bytes=%h, ",
                         "got st=%0d h=%h sz=%h cnt=%0d bytes=%h"},
                        oldest.status, oldest.handle, oldest.size, oldest.count,
                        oldest.bytes, m_status, m_out_handle, m_out_size,
                        m_entry_total, m_bytes_held));
                end
            end
        end
        if (aresetn && s_valid && s_ready)
            pending_results.push_back(predict_result(action_t'(s_action),
                                                     s_pkt_handle, s_pkt_size));
        if (aresetn && cfg_valid && cfg_ready)
            shadow_limit = cfg_byte_limit;
    end

    // result sink: shifting stall patterns, plus a long hold on request
    initial begin : sink
        int mode;
        int mode_left;
        int tick;
        mode      = 0;
        mode_left = 0;
        tick      = 0;
        forever begin
            @(posedge aclk);
            tick++;
            if (sink_hold_req) begin
                m_ready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(posedge aclk);
                sink_hold_req = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(16, 96);
                end else begin
                    mode_left--;
                end
                case (mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom_range(0, 1));
                    2:       m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= (tick % 3 != 0);
                endcase
            end
        end
    end

    // offer one request and hold it until accepted; bursts end in a gap
    task automatic send_request(input action_t act, input logic [HANDLE_W-1:0] handle,
                                input logic [SIZE_W-1:0] size);
        s_valid      <= 1'b1;
        s_action     <= act;
        s_pkt_handle <= handle;
        s_pkt_size   <= size;
        do @(posedge aclk); while (!s_ready);
        requests_sent++;
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 16);
        end else begin
            burst_left--;
        end
    endtask

    // wait until every outstanding result is back and the pipeline is quiet
    task automatic drain_results();
        s_valid <= 1'b0;
        while (results_seen < requests_sent) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_byte_limit(input logic [BYTES_W-1:0] value);
        drain_results();
        cfg_valid      <= 1'b1;
        cfg_byte_limit <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic push(input logic [SIZE_W-1:0] size);
        send_request(ACT_PUSH, $urandom, size);
    endtask

    task automatic other(input action_t act);
        send_request(act, $urandom, SIZE_W'($urandom));
    endtask

    // edges at the reset budget: empty pop, exact limit, unused action, flush
    task automatic test_reset_defaults();
        other(ACT_POP);
        other(ACT_NONE);
        send_request(ACT_PUSH, '0, '0);
        send_request(ACT_PUSH, '1, '1);
        send_request(ACT_PUSH, 32'hA5A5_A5A5, SIZE_W'(BYTE_LIMIT_RESET));
        push('0);
        push(24'd1);
        other(ACT_POP);
        other(ACT_POP);
        other(ACT_POP);
        other(ACT_POP);
        push(24'd77);
        push(24'd12345);
        other(ACT_NONE);
        other(ACT_FLUSH);
        other(ACT_POP);
        push(24'd9);
        other(ACT_POP);
    endtask

    // zero budget: only empty packets fit
    task automatic test_zero_limit();
        set_byte_limit('0);
        other(ACT_FLUSH);
        push('0);
        push(24'd1);
        push('1);
        other(ACT_POP);
        other(ACT_POP);
    endtask

    // budget lowered under the held bytes: nothing dropped, pushes wait for pops
    task automatic test_limit_lowered();
        set_byte_limit(32'd10000);
        other(ACT_FLUSH);
        repeat (4) push(24'd2000);
        set_byte_limit(32'd3000);
        push('0);
        push(24'd1);
        repeat (3) other(ACT_POP);
        push(24'd1000);
        push(24'd1);
        repeat (3) other(ACT_POP);
    endtask

    // byte total right up to the 32-bit ceiling
    task automatic test_budget_ceiling();
        set_byte_limit('1);
        other(ACT_FLUSH);
        repeat (256) push('1);
        push('1);
        push(24'd255);
        push('0);
        push(24'd1);
        other(ACT_POP);
        push(24'd1);
        other(ACT_FLUSH);
    endtask

    // sink held off while requests keep coming, so the input stalls
    task automatic test_sink_backpressure();
        sink_hold_req = 1'b1;
        burst_left    = 1000;
        repeat (48) begin
            if ($urandom_range(0, 2) == 0)
                other(ACT_POP);
            else
                push(SIZE_W'($urandom_range(0, 65535)));
        end
        burst_left = 0;
    endtask

    task automatic run_traffic(input int n_items, input int push_pct, input int pop_pct,
                               input int size_max);
        int                 pick;
        action_t            act;
        logic [SIZE_W-1:0]  size;
        for (int i = 0; i < n_items; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < push_pct)
                act = ACT_PUSH;
            else if (pick < push_pct + pop_pct)
                act = ACT_POP;
            else if (pick < push_pct + pop_pct + 3)
                act = ACT_FLUSH;
            else
                act = ACT_NONE;
            case ($urandom_range(0, 9))
                0:       size = '0;
                1:       size = SIZE_W'($urandom);
                2:       size = '1;
                default: size = SIZE_W'($urandom_range(0, size_max));
            endcase
            send_request(act, $urandom, size);
        end
    endtask

    // random mixed traffic under several budgets
    task automatic test_random_traffic();
        set_byte_limit(BYTE_LIMIT_RESET);
        run_traffic(70, 50, 42, 65535);
        set_byte_limit($urandom_range(1000, 200000));
        run_traffic(70, 55, 38, 8191);
        set_byte_limit('1);
        run_traffic(70, 60, 32, 16777215);
        set_byte_limit($urandom);
        run_traffic(70, 50, 45, 1 << 20);
        set_byte_limit('0);
        run_traffic(70, 45, 45, 15);
    endtask

    // main sequence
    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_zero_limit();
        test_limit_lowered();
        test_budget_ceiling();
        test_sink_backpressure();
        test_random_traffic();

        drain_results();
        repeat (8) @(posedge aclk);

        $display("covered %0d requests: %0d pushes kept, %0d rejected full, %0d pops, %0d empty",
                 requests_sent, n_push_ok, n_push_full, n_pop_ok, n_pop_empty);
        $display("flushes %0d, unused actions %0d, deepest fill %0d, mismatches %0d",
                 n_flush, n_idle_action, peak_count, mismatch_count);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: byte_budget_packet_fifo.f
hw/rtl/bbpf_pkg.sv
hw/rtl/bbpf_ctrl.sv
hw/rtl/bbpf_dpath.sv
hw/rtl/byte_budget_packet_fifo.sv
hw/rtl/bbpf_checker.sv
tb/tb_byte_budget_packet_fifo.sv
